// File: hdl/pre_trade_risk_check_defines.svh
// Assertion macros for the pre-trade risk check block.
// Included by the files that carry concurrent assertions; needs no package.
`ifndef PRE_TRADE_RISK_CHECK_DEFINES_SVH
`define PRE_TRADE_RISK_CHECK_DEFINES_SVH

`ifndef SYNTH
`define PTRC_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pre_trade_risk_check assertion failed");
`define PTRC_ASSERT_NR(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("pre_trade_risk_check reset assertion failed");
`else
`define PTRC_ASSERT(name, clk, rst_n, prop)
`define PTRC_ASSERT_NR(name, clk, prop)
`endif

`endif

// File: hdl/ptrc_pkg.sv
// Shared types, codes, reset values and saturating arithmetic for the risk check.
// Used by the interfaces, the update logic and the top level; depends on nothing.
package ptrc_pkg;

  localparam int CLIENTS_DEF = 16;
  localparam int SYMBOLS_DEF = 64;
  localparam int CLIENT_W    = 4;
  localparam int SYMBOL_W    = 6;

  typedef logic        [2:0]  op_t;
  typedef logic        [CLIENT_W-1:0] client_t;
  typedef logic        [SYMBOL_W-1:0] symbol_t;
  typedef logic signed [31:0] price_t;
  typedef logic        [31:0] qty_t;
  typedef logic signed [63:0] val_t;
  typedef logic        [62:0] lim_t;
  typedef logic        [1:0]  cfg_idx_t;

  localparam op_t OP_CHECK   = 3'd0;
  localparam op_t OP_ACCEPT  = 3'd1;
  localparam op_t OP_CLOSE   = 3'd2;
  localparam op_t OP_FILL    = 3'd3;
  localparam op_t OP_SET_PNL = 3'd4;
  localparam op_t OP_KILL    = 3'd5;
  localparam op_t OP_CLEAR   = 3'd6;

  localparam cfg_idx_t REG_MAX_ORDER_QTY = 2'd0;
  localparam cfg_idx_t REG_MAX_LOSS      = 2'd1;
  localparam cfg_idx_t REG_MAX_POSITION  = 2'd2;
  localparam cfg_idx_t REG_MAX_NOTIONAL  = 2'd3;

  localparam qty_t MAX_ORDER_QTY_RST = 32'd1000000;
  localparam lim_t MAX_LOSS_RST      = 63'd1000000000;
  localparam lim_t MAX_POSITION_RST  = 63'd1000000;
  localparam lim_t MAX_NOTIONAL_RST  = 63'd1000000000000;

  localparam val_t VAL_MAX = {1'b0, {63{1'b1}}};
  localparam val_t VAL_MIN = {1'b1, {63{1'b0}}};

  typedef struct packed {
    val_t position;
    val_t notional;
    val_t pnl;
    logic killed;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Precomputed sums and flags handed from the evaluate stage to the update logic.
  typedef struct packed {
    entry_t ent;
    val_t   pos_sum;
    val_t   not_add;
    val_t   not_sub;
    val_t   not_room;
    logic   loss_hit;
    logic   qty_ok;
    logic   notional_neg;
    op_t    op;
    logic   is_market;
    val_t   pnl;
    logic   pnl_loss;
  } ex_t;

  typedef struct packed {
    logic   allowed;
    entry_t ent;
  } upd_t;

  function automatic val_t sat_add(input val_t a, input val_t b);
    val_t r;
    r = a + b;
    if (!a[63] && !b[63] && r[63]) return VAL_MAX;
    if (a[63] && b[63] && !r[63]) return VAL_MIN;
    return r;
  endfunction

  function automatic val_t sat_sub(input val_t a, input val_t b);
    val_t r;
    r = a - b;
    if (!a[63] && b[63] && r[63]) return VAL_MAX;
    if (a[63] && !b[63] && !r[63]) return VAL_MIN;
    return r;
  endfunction

endpackage

// File: hdl/ptrc_if.sv
// Valid/ready channel interfaces for order events and risk results.
// Depends on ptrc_pkg for the payload types.
interface ptrc_in_if;
  import ptrc_pkg::*;

  logic    valid;
  logic    ready;
  op_t     op;
  client_t client;
  symbol_t symbol;
  logic    side;
  logic    is_market;
  price_t  price;
  qty_t    quantity;
  val_t    pnl;

  modport source (output valid, op, client, symbol, side, is_market, price, quantity, pnl,
                  input ready);
  modport sink (input valid, op, client, symbol, side, is_market, price, quantity, pnl,
                output ready);
endinterface

interface ptrc_out_if;
  import ptrc_pkg::*;

  logic valid;
  logic ready;
  logic allowed;
  val_t position;
  val_t exposure;
  val_t booked_pnl;
  logic killed;

  modport source (output valid, allowed, position, exposure, booked_pnl, killed,
                  input ready);
  modport sink (input valid, allowed, position, exposure, booked_pnl, killed,
                output ready);
endinterface

// File: hdl/ptrc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; holds the risk table entries.
module ptrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/ptrc_update.sv
// Final risk decision and new entry value for one operation.
// Depends on ptrc_pkg for the entry, stage and result types.
module ptrc_update (
  input  ptrc_pkg::ex_t  ex,
  input  ptrc_pkg::lim_t max_position,
  output ptrc_pkg::upd_t upd
);
  import ptrc_pkg::*;

  logic [63:0] pos_mag;
  logic        pos_ok;
  logic        notional_ok;
  logic        chk_ok;
  val_t        not_clamp;

  always_comb begin
    pos_mag     = ex.pos_sum[63] ? 64'(-ex.pos_sum) : 64'(ex.pos_sum);
    pos_ok      = pos_mag <= {1'b0, max_position};
    notional_ok = ex.is_market || (!ex.notional_neg && !(ex.ent.notional > ex.not_room));
    chk_ok      = ex.qty_ok && !ex.ent.killed && !ex.loss_hit && pos_ok && notional_ok;
    not_clamp   = ex.not_sub[63] ? '0 : ex.not_sub;

    upd.allowed = 1'b0;
    upd.ent     = ex.ent;
    case (ex.op)
      OP_CHECK: begin
        upd.allowed = chk_ok;
      end
      OP_ACCEPT: begin
        if (!ex.is_market) begin
          upd.ent.notional = ex.not_add;
        end
      end
      OP_CLOSE: begin
        upd.ent.notional = not_clamp;
      end
      OP_FILL: begin
        upd.ent.position = ex.pos_sum;
        upd.ent.notional = not_clamp;
      end
      OP_SET_PNL: begin
        upd.ent.pnl    = ex.pnl;
        upd.ent.killed = ex.ent.killed | ex.pnl_loss;
      end
      OP_KILL: begin
        upd.ent.killed = 1'b1;
      end
      OP_CLEAR: begin
        upd.ent = '0;
      end
      default: begin
      end
    endcase
  end

endmodule

// File: hdl/pre_trade_risk_check.sv
// Pre-trade risk check top level: one table entry per client and symbol in a single RAM.
// A transaction is accepted only when idle; it passes through the read, evaluate and
// write-back states of the one entry RAM; write-back waits while the output is stalled.
// After reset a clearing pass writes zero to all CLIENTS * SYMBOLS entries, one per cycle,
// before the first transaction is accepted; limit registers reset to their defaults.
`include "pre_trade_risk_check_defines.svh"

module pre_trade_risk_check #(
  parameter int CLIENTS = ptrc_pkg::CLIENTS_DEF,
  parameter int SYMBOLS = ptrc_pkg::SYMBOLS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  ptrc_in_if.sink            in_ch,
  ptrc_out_if.source         out_ch,
  input  logic               cfg_we,
  input  ptrc_pkg::cfg_idx_t cfg_index,
  input  ptrc_pkg::lim_t     cfg_wdata
);
  import ptrc_pkg::*;

  localparam int ENTRIES = CLIENTS * SYMBOLS;
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
  localparam int SW = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_EX   = 3'd3;
  localparam logic [2:0] S_WB   = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic          out_valid_r, out_valid_nxt;

  qty_t max_order_qty_r;
  lim_t max_loss_r;
  lim_t max_position_r;
  lim_t max_notional_r;

  logic [CW-1:0] client_mod_tab [2**CLIENT_W];
  logic [SW-1:0] symbol_mod_tab [2**SYMBOL_W];
  logic [AW-1:0] in_addr;
  logic          in_go;
  logic          wb_go;

  logic [AW-1:0] addr_r;
  op_t           op_r;
  logic          side_r;
  logic          market_r;
  price_t        price_r;
  qty_t          qty_r;
  val_t          pnl_r;
  val_t          notional_r;
  logic          pnl_loss_r;
  logic signed [64:0] prod;
  val_t          neg_loss;
  val_t          sqty;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  ex_t  ex_nxt, ex_r;
  upd_t upd;

  logic allowed_r;
  entry_t out_ent_r;

  // Client and symbol are folded into the table by constant lookup.
  for (genvar i = 0; i < 2**CLIENT_W; i++) begin : g_cmod
    assign client_mod_tab[i] = CW'(i % CLIENTS);
  end
  for (genvar j = 0; j < 2**SYMBOL_W; j++) begin : g_smod
    assign symbol_mod_tab[j] = SW'(j % SYMBOLS);
  end

  assign in_addr = AW'(client_mod_tab[in_ch.client]) * AW'(SYMBOLS)
                 + AW'(symbol_mod_tab[in_ch.symbol]);

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_go       = in_ch.valid && in_ch.ready;
  assign wb_go       = (state_r == S_WB) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      S_CLR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(ENTRIES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_go) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_EX;
      end
      S_EX: begin
        state_nxt = S_WB;
      end
      S_WB: begin
        if (wb_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (wb_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_CLR;
      clr_cnt_r       <= '0;
      out_valid_r     <= 1'b0;
      max_order_qty_r <= MAX_ORDER_QTY_RST;
      max_loss_r      <= MAX_LOSS_RST;
      max_position_r  <= MAX_POSITION_RST;
      max_notional_r  <= MAX_NOTIONAL_RST;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_ORDER_QTY: max_order_qty_r <= cfg_wdata[31:0];
          REG_MAX_LOSS:      max_loss_r      <= cfg_wdata;
          REG_MAX_POSITION:  max_position_r  <= cfg_wdata;
          REG_MAX_NOTIONAL:  max_notional_r  <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  assign prod     = $signed({1'b0, qty_r}) * price_r;
  assign neg_loss = -val_t'({1'b0, max_loss_r});
  assign sqty     = side_r ? -val_t'({32'b0, qty_r}) : val_t'({32'b0, qty_r});

  always_comb begin
    ex_nxt.ent          = entry_t'(ram_rdata);
    ex_nxt.pos_sum      = sat_add(ex_nxt.ent.position, sqty);
    ex_nxt.not_add      = sat_add(ex_nxt.ent.notional, notional_r);
    ex_nxt.not_sub      = sat_sub(ex_nxt.ent.notional, notional_r);
    ex_nxt.not_room     = val_t'({1'b0, max_notional_r}) - notional_r;
    ex_nxt.loss_hit     = ex_nxt.ent.pnl <= neg_loss;
    ex_nxt.qty_ok       = (qty_r != '0) && (qty_r <= max_order_qty_r);
    ex_nxt.notional_neg = notional_r[63];
    ex_nxt.op           = op_r;
    ex_nxt.is_market    = market_r;
    ex_nxt.pnl          = pnl_r;
    ex_nxt.pnl_loss     = pnl_loss_r;
  end

  always_ff @(posedge clk) begin
    if (in_go) begin
      addr_r   <= in_addr;
      op_r     <= in_ch.op;
      side_r   <= in_ch.side;
      market_r <= in_ch.is_market;
      price_r  <= in_ch.price;
      qty_r    <= in_ch.quantity;
      pnl_r    <= in_ch.pnl;
    end
    if (state_r == S_RD) begin
      notional_r <= prod[63:0];
      pnl_loss_r <= pnl_r <= neg_loss;
    end
    if (state_r == S_EX) begin
      ex_r <= ex_nxt;
    end
    if (wb_go) begin
      allowed_r <= upd.allowed;
      out_ent_r <= upd.ent;
    end
  end

  ptrc_update u_update (
    .ex           (ex_r),
    .max_position (max_position_r),
    .upd          (upd)
  );

  assign ram_we    = (state_r == S_CLR) || wb_go;
  assign ram_waddr = (state_r == S_CLR) ? clr_cnt_r : addr_r;
  assign ram_wdata = (state_r == S_CLR) ? '0 : ENTRY_W'(upd.ent);

  ptrc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_go),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  assign out_ch.valid      = out_valid_r;
  assign out_ch.allowed    = allowed_r;
  assign out_ch.position   = out_ent_r.position;
  assign out_ch.exposure   = out_ent_r.notional;
  assign out_ch.booked_pnl = out_ent_r.pnl;
  assign out_ch.killed     = out_ent_r.killed;

  `PTRC_ASSERT(a_wb_out, clk, rst_n, wb_go |=> out_valid_r)
  `PTRC_ASSERT(a_allow_check, clk, rst_n, wb_go && upd.allowed |-> ex_r.op == OP_CHECK)
  `PTRC_ASSERT(a_kill_blocks, clk, rst_n, wb_go && ex_r.ent.killed |-> !upd.allowed)
  `PTRC_ASSERT_NR(a_reset_clr, clk, !rst_n |=> state_r == S_CLR)

endmodule
